### sv/garage_door_state_controller_unit_macros.svh
// assertion macros for the rtl files, included by gdsc_out_queue
`ifndef GARAGE_DOOR_STATE_CONTROLLER_UNIT_MACROS_SVH
`define GARAGE_DOOR_STATE_CONTROLLER_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GDSC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define GDSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/gdsc_pkg.sv
`default_nettype none

package gdsc_pkg;

  // field and counter widths
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 16;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // output queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_AW + 1;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] CFG_PRESS_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_OPEN_PRESENT = 2'd2;
  localparam logic [1:0] CFG_CLOSE_PRESENT = 2'd3;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = CFG_W'(50);
  localparam logic [CFG_W-1:0] PRESS_WIDTH_RST = CFG_W'(500);

  // request kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  // result kinds
  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_PRESS  = 1'b1;

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_CLOSE  = 3'd1,
    CMD_LOCK   = 3'd2,
    CMD_UNLOCK = 3'd3,
    CMD_STOP   = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    DOOR_UNKNOWN = 3'd0,
    DOOR_CLOSED  = 3'd1,
    DOOR_OPENED  = 3'd2,
    DOOR_OPENING = 3'd3,
    DOOR_CLOSING = 3'd4
  } door_state_t;

  typedef enum logic [1:0] {
    RELAY_OPEN  = 2'd0,
    RELAY_CLOSE = 2'd1,
    RELAY_STOP  = 2'd2,
    RELAY_LOCK  = 2'd3
  } relay_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  // input request payload
  typedef struct packed {
    logic       req_type;
    logic       open_sensor_level;
    logic       close_sensor_level;
    logic [2:0] command_code;
  } in_t;

  // result payload
  typedef struct packed {
    logic             result_kind;
    logic [1:0]       press_relay;
    logic [CFG_W-1:0] pulse_ticks;
    logic [2:0]       door_state;
    logic             lock_marked;
    logic             locked_flag;
    logic             state_changed;
    logic             last_of_run;
  } out_t;

  // configuration register set
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] press_width;
    logic             open_present;
    logic             close_present;
  } cfg_t;

endpackage

`default_nettype wire

### sv/gdsc_debounce.sv
`default_nettype none

module gdsc_debounce (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    level,
  input  logic [gdsc_pkg::CFG_W-1:0] thresh,
  output logic                    stable_nxt
);
  import gdsc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic             raw_r, raw_nxt;
  logic             stable_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // raw tracking, saturating hold count, stable update
  always_comb begin
    raw_nxt    = raw_r;
    cnt_nxt    = cnt_r;
    stable_nxt = stable_r;
    if (en) begin
      if (level != raw_r) begin
        raw_nxt = level;
        cnt_nxt = '0;
      end else if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (CMP_W'(cnt_nxt) >= CMP_W'(thresh)) begin
        stable_nxt = raw_nxt;
      end
    end
  end

  // sensor levels reset inactive (high)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b1;
      stable_r <= 1'b1;
      cnt_r    <= '0;
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/gdsc_core.sv
`default_nettype none

module gdsc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  gdsc_pkg::in_t  item,
  input  gdsc_pkg::cfg_t cfg,
  input  logic           open_stable_nxt,
  input  logic           close_stable_nxt,
  output logic [1:0]     push_cnt,
  output gdsc_pkg::out_t res0,
  output gdsc_pkg::out_t res1
);
  import gdsc_pkg::*;

  door_state_t state_r, state_nxt;
  logic [3:0]  reported_r, reported_nxt;
  dir_t        dir_r, dir_nxt;
  logic        mark_r, mark_nxt;
  logic        locked_r, locked_nxt;

  logic        oa, ca, plain;
  logic        set_en;
  door_state_t set_val;

  function automatic out_t make_res(logic kind, relay_t relay, logic [CFG_W-1:0] pulse,
                                    door_state_t st, logic mark, logic locked,
                                    logic [3:0] reported, logic last);
    out_t r;
    r.result_kind   = kind;
    r.press_relay   = relay;
    r.pulse_ticks   = pulse;
    r.door_state    = st;
    r.lock_marked   = mark;
    r.locked_flag   = locked;
    r.state_changed = ({mark, st} != reported);
    r.last_of_run   = last;
    return r;
  endfunction

  // endpoint activity after this tick's debounce
  assign oa    = cfg.open_present && !open_stable_nxt;
  assign ca    = cfg.close_present && !close_stable_nxt;
  assign plain = !mark_r;

  // door state derivation for a tick
  always_comb begin
    set_en  = 1'b0;
    set_val = DOOR_UNKNOWN;
    dir_nxt = dir_r;
    if (oa && ca) begin
      set_en  = 1'b1;
      set_val = DOOR_UNKNOWN;
      dir_nxt = DIR_NONE;
    end else if (ca) begin
      set_en  = 1'b1;
      set_val = DOOR_CLOSED;
      dir_nxt = DIR_NONE;
    end else if (oa) begin
      set_en  = 1'b1;
      set_val = DOOR_OPENED;
      dir_nxt = DIR_NONE;
    end else if (dir_r == DIR_OPEN) begin
      set_en  = 1'b1;
      set_val = DOOR_OPENING;
    end else if (dir_r == DIR_CLOSE) begin
      set_en  = 1'b1;
      set_val = DOOR_CLOSING;
    end else if (!cfg.open_present && !cfg.close_present) begin
      // no sensors: keep a plain motion state, otherwise unknown
      if (!(plain && (state_r inside {DOOR_OPENING, DOOR_CLOSING}))) begin
        set_en  = 1'b1;
        set_val = DOOR_UNKNOWN;
      end
    end else if (plain && state_r == DOOR_CLOSED) begin
      set_en  = 1'b1;
      set_val = DOOR_OPENING;
    end else if (plain && state_r == DOOR_OPENED) begin
      set_en  = 1'b1;
      set_val = DOOR_CLOSING;
    end
  end

  // state update and result formation
  always_comb begin
    state_nxt    = state_r;
    mark_nxt     = mark_r;
    locked_nxt   = locked_r;
    reported_nxt = reported_r;
    push_cnt     = 2'd0;
    res0         = '0;
    res1         = '0;
    if (fire) begin
      if (item.req_type == REQ_TICK) begin
        if (set_en) begin
          state_nxt = set_val;
          mark_nxt  = 1'b0;
        end
        res0 = make_res(RES_REPORT, RELAY_OPEN, '0, state_nxt, mark_nxt, locked_r,
                        reported_r, 1'b1);
        reported_nxt = {mark_nxt, state_nxt};
        push_cnt     = 2'd1;
      end else begin
        case (cmd_code_t'(item.command_code))
          CMD_OPEN: begin
            res0 = make_res(RES_PRESS, RELAY_OPEN, cfg.press_width, state_r, mark_r,
                            locked_r, reported_r, 1'b1);
            push_cnt = 2'd1;
          end
          CMD_CLOSE: begin
            res0 = make_res(RES_PRESS, RELAY_CLOSE, cfg.press_width, state_r, mark_r,
                            locked_r, reported_r, 1'b1);
            push_cnt = 2'd1;
          end
          CMD_LOCK: begin
            mark_nxt   = 1'b1;
            locked_nxt = 1'b1;
            res0 = make_res(RES_PRESS, RELAY_LOCK, cfg.press_width, state_r, 1'b1,
                            1'b1, reported_r, 1'b1);
            push_cnt = 2'd1;
          end
          CMD_UNLOCK: begin
            // two stop presses, the second shows the lock released
            mark_nxt   = 1'b0;
            locked_nxt = 1'b0;
            res0 = make_res(RES_PRESS, RELAY_STOP, cfg.press_width, state_r, 1'b0,
                            locked_r, reported_r, 1'b0);
            res1 = make_res(RES_PRESS, RELAY_STOP, cfg.press_width, state_r, 1'b0,
                            1'b0, reported_r, 1'b1);
            push_cnt = 2'd2;
          end
          CMD_STOP: begin
            mark_nxt = 1'b0;
            res0 = make_res(RES_PRESS, RELAY_STOP, cfg.press_width, state_r, 1'b0,
                            locked_r, reported_r, 1'b1);
            push_cnt = 2'd1;
          end
          default: begin
            push_cnt = 2'd0;
          end
        endcase
      end
    end
  end

  // direction only moves on open/close commands or tick decisions
  dir_t dir_upd;
  always_comb begin
    dir_upd = dir_r;
    if (fire) begin
      if (item.req_type == REQ_TICK) begin
        dir_upd = dir_nxt;
      end else if (cmd_code_t'(item.command_code) == CMD_OPEN) begin
        dir_upd = DIR_OPEN;
      end else if (cmd_code_t'(item.command_code) == CMD_CLOSE) begin
        dir_upd = DIR_CLOSE;
      end
    end
  end

  // door state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= DOOR_UNKNOWN;
      reported_r <= '0;
      dir_r      <= DIR_NONE;
      mark_r     <= 1'b0;
      locked_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      reported_r <= reported_nxt;
      dir_r      <= dir_upd;
      mark_r     <= mark_nxt;
      locked_r   <= locked_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/gdsc_out_queue.sv
`default_nettype none

module gdsc_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  gdsc_pkg::out_t push0,
  input  gdsc_pkg::out_t push1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output gdsc_pkg::out_t out_data
);
  import gdsc_pkg::*;

  `include "garage_door_state_controller_unit_macros.svh"

  out_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic             pop;

  // room for a full two-result request
  assign room      = (count_r <= OQ_CW'(OQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
    count_nxt  = count_r + OQ_CW'(push_cnt) - OQ_CW'(pop);
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // occupancy checks
  `GDSC_ASSERT_ALWAYS(a_count_bound, count_r <= OQ_CW'(OQ_DEPTH), "queue count out of range")
  `GDSC_ASSERT_IMPL(a_push_room, push_cnt != 2'd0, room, "push into queue without room")
  `GDSC_ASSERT_NEXT(a_count_hold, (push_cnt == 2'd0) && !pop, $stable(count_r), "queue count moved")

endmodule

`default_nettype wire

### sv/garage_door_state_controller_unit.sv
`default_nettype none

// Garage door state controller.
// in_*   : requests, either a tick carrying the two active-low endpoint
//          sensor levels or a door command; accepted when in_valid is high
//          and in_stall is low.
// out_*  : results, a state report per tick, one press per command and two
//          stop presses for unlock; taken when out_valid is high and
//          out_stall is low. last_of_run marks a request's final result.
// cfg_*  : register writes (index, data), always ready; write only while
//          no request is in flight.
// A request passes through the request register and then through the state
// update into the result queue, which drives out_*. One request is accepted
// every cycle while the result queue has room; an unlock request produces
// two results, which leave the output one at a time.
// The four-entry result queue sets the limit: a request leaves the request
// register only when two entries are free, so a stalled receiver backs up
// into in_stall after a few requests without losing any result.
// Synchronous reset clears the sensor debouncers, door state, lock flags,
// the queue, and loads the register defaults (50, 500, both sensors fitted).
module garage_door_state_controller_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gdsc_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gdsc_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [gdsc_pkg::CFG_W-1:0] cfg_data
);
  import gdsc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       item_v_r, item_v_nxt;
  in_t        item_r;
  logic       in_acc, fire, room;
  logic       open_stable_nxt, close_stable_nxt;
  logic [1:0] push_cnt;
  out_t       res0, res1;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:      cfg_nxt.debounce_ticks = cfg_data;
        CFG_PRESS_WIDTH:   cfg_nxt.press_width    = cfg_data;
        CFG_OPEN_PRESENT:  cfg_nxt.open_present   = cfg_data[0];
        CFG_CLOSE_PRESENT: cfg_nxt.close_present  = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.press_width    <= PRESS_WIDTH_RST;
      cfg_r.open_present   <= 1'b1;
      cfg_r.close_present  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request register handshake
  assign fire       = item_v_r && room;
  assign in_stall   = item_v_r && !room;
  assign in_acc     = in_valid && !in_stall;
  assign item_v_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : item_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  // endpoint sensor debouncers
  gdsc_debounce u_open_db (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (fire && (item_r.req_type == REQ_TICK) && cfg_r.open_present),
    .level      (item_r.open_sensor_level),
    .thresh     (cfg_r.debounce_ticks),
    .stable_nxt (open_stable_nxt)
  );

  gdsc_debounce u_close_db (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (fire && (item_r.req_type == REQ_TICK) && cfg_r.close_present),
    .level      (item_r.close_sensor_level),
    .thresh     (cfg_r.debounce_ticks),
    .stable_nxt (close_stable_nxt)
  );

  // door state and result formation
  gdsc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .item             (item_r),
    .cfg              (cfg_r),
    .open_stable_nxt  (open_stable_nxt),
    .close_stable_nxt (close_stable_nxt),
    .push_cnt         (push_cnt),
    .res0             (res0),
    .res1             (res1)
  );

  // result queue
  gdsc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
